>>> hdl/au_header_section_depacketizer_top_macros.svh
// ----------------------------------------------------------------------------
// AU header depacketizer assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AU_HEADER_SECTION_DEPACKETIZER_TOP_MACROS_SVH
`define AU_HEADER_SECTION_DEPACKETIZER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define AUHDP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define AUHDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/auhdp_pkg.sv
// ----------------------------------------------------------------------------
// AU header depacketizer package
// Shared widths, register codes, result kinds and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package auhdp_pkg;

  localparam int unsigned MAX_AU_HEADERS_DEF = 64;

  localparam int BYTE_W  = 8;
  localparam int WIDTH_W = 5;
  localparam int LEN_W   = 16;
  localparam int NUM_W   = 6;
  localparam int HB_W    = 14;

  typedef logic [WIDTH_W-1:0] fwidth_t;
  typedef logic [1:0]         cfg_idx_t;
  typedef logic [1:0]         kind_t;

  localparam cfg_idx_t CFG_SIZE_BITS  = 2'd0;
  localparam cfg_idx_t CFG_INDEX_BITS = 2'd1;
  localparam cfg_idx_t CFG_DELTA_BITS = 2'd2;

  localparam fwidth_t SIZE_BITS_RST  = 5'd13;
  localparam fwidth_t INDEX_BITS_RST = 5'd3;
  localparam fwidth_t DELTA_BITS_RST = 5'd3;

  localparam kind_t KIND_AU   = 2'd0;
  localparam kind_t KIND_DONE = 2'd1;
  localparam kind_t KIND_ERR  = 2'd2;

  typedef enum logic [3:0] {
    ST_LEN_HI,
    ST_LEN_LO,
    ST_DIV,
    ST_HDR,
    ST_SKIP_RD,
    ST_SKIP_CHK,
    ST_PAYLOAD,
    ST_DROP,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

>>> hdl/auhdp_ram.sv
// ----------------------------------------------------------------------------
// AU header depacketizer table RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module auhdp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/au_header_section_depacketizer_top.sv
// ----------------------------------------------------------------------------
// AU header section depacketizer
// Parses the AU header section of one RTP payload into size and index tables,
// then tags each payload byte with its AU and reports packet status.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Word
// in_      in   in_valid/in_stall    payload byte with packet end mark
// out_     out  out_valid/out_stall  AU byte, or done/error status
// cfg_     in   cfg_wr_en            size/index/delta field width
//
// Each length byte is consumed from the input register; the second starts a
// restoring divide that yields the header count. A header byte is shifted in
// one header bit at a time, with a step per zero-width index or delta field
// and one to retire the byte. Payload bytes pass through the input register;
// each table entry read at an AU boundary goes through ST_SKIP_RD and
// ST_SKIP_CHK (registered RAM read). Packet end emits the status word in
// ST_FIN. Reset restores the field widths 13/3/3 and keeps the tables.
// ----------------------------------------------------------------------------
`default_nettype none

module au_header_section_depacketizer_top #(
  parameter int unsigned MAX_AU_HEADERS = auhdp_pkg::MAX_AU_HEADERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [auhdp_pkg::BYTE_W-1:0] in_payload_byte,
  input  logic                        in_packet_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output auhdp_pkg::kind_t            out_kind,
  output logic [auhdp_pkg::BYTE_W-1:0] out_byte,
  output logic [auhdp_pkg::NUM_W-1:0] out_au_number,
  output logic [auhdp_pkg::LEN_W-1:0] out_au_length,
  output logic [auhdp_pkg::LEN_W-1:0] out_au_index_field,
  output logic                        out_au_last,
  input  logic                        cfg_wr_en,
  input  auhdp_pkg::cfg_idx_t         cfg_index,
  input  auhdp_pkg::fwidth_t          cfg_wdata
);

  import auhdp_pkg::*;

  localparam int AW = (MAX_AU_HEADERS > 1) ? $clog2(MAX_AU_HEADERS) : 1;
  localparam int CW = $clog2(MAX_AU_HEADERS + 1);

  state_t state_r, state_nxt;
  logic in_full_r;
  logic [BYTE_W-1:0] byte_r;
  logic end_r;

  fwidth_t cfg_s_r, cfg_i_r, cfg_d_r;
  fwidth_t lat_s_r, lat_s_nxt, lat_i_r, lat_i_nxt, lat_d_r, lat_d_nxt;

  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [HB_W-1:0] hdr_bytes_r, hdr_bytes_nxt, bytes_seen_r, bytes_seen_nxt;
  logic [LEN_W-1:0] dvd_r, dvd_nxt;
  logic [5:0] rem_r, rem_nxt;
  logic [3:0] div_cnt_r, div_cnt_nxt;

  logic [CW-1:0] hcount_r, hcount_nxt, parsed_r, parsed_nxt, cur_r, cur_nxt;
  logic fii_r, fii_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic [WIDTH_W-1:0] held_r, held_nxt;
  logic [3:0] bcnt_r, bcnt_nxt;
  logic [LEN_W-1:0] left_r, left_nxt, au_len_r, au_len_nxt, au_idx_r, au_idx_nxt;
  kind_t fin_kind_r, fin_kind_nxt;

  logic out_valid_r;
  kind_t ok_kind_r;
  logic [BYTE_W-1:0] ob_r;
  logic [NUM_W-1:0] onum_r;
  logic [LEN_W-1:0] olen_r, oidx_r;
  logic olast_r;

  logic in_accept, consume, out_free, emit;
  kind_t ev_kind;
  logic [BYTE_W-1:0] ev_byte;
  logic [NUM_W-1:0] ev_num;
  logic [LEN_W-1:0] ev_len, ev_idx;
  logic ev_last;

  logic [LEN_W-1:0] hdr_total;
  logic [5:0] si, sd;
  logic [6:0] trial;
  logic trial_ge;
  logic [5:0] div_rem;
  logic [LEN_W-1:0] div_dvd;

  fwidth_t cur_w;
  logic hdr_more, pending, bit_in;
  logic [2:0] bit_sel;
  logic [LEN_W-1:0] shift_acc;
  logic [WIDTH_W-1:0] shift_held;
  logic store;
  logic [LEN_W-1:0] store_val;
  logic [LEN_W-1:0] size_rd, index_rd;

  assign in_stall  = in_full_r;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign hdr_total = {len_hi_r, byte_r};
  assign si        = 6'(cfg_s_r) + 6'(cfg_i_r);
  assign sd        = 6'(lat_s_r) + 6'(lat_d_r);
  assign trial     = {rem_r, dvd_r[LEN_W-1]};
  assign trial_ge  = trial >= {1'b0, sd};
  assign div_rem   = trial_ge ? 6'(trial - {1'b0, sd}) : trial[5:0];
  assign div_dvd   = {dvd_r[LEN_W-2:0], trial_ge};

  assign cur_w      = !fii_r ? lat_s_r : ((parsed_r == '0) ? lat_i_r : lat_d_r);
  assign hdr_more   = parsed_r < hcount_r;
  assign pending    = hdr_more && (held_r == cur_w);
  assign bit_sel    = 3'(bcnt_r - 4'd1);
  assign bit_in     = byte_r[bit_sel];
  assign shift_acc  = {acc_r[LEN_W-2:0], bit_in};
  assign shift_held = held_r + 5'd1;

  always_comb begin
    state_nxt      = state_r;
    lat_s_nxt      = lat_s_r;
    lat_i_nxt      = lat_i_r;
    lat_d_nxt      = lat_d_r;
    len_hi_nxt     = len_hi_r;
    hdr_bytes_nxt  = hdr_bytes_r;
    bytes_seen_nxt = bytes_seen_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    hcount_nxt     = hcount_r;
    parsed_nxt     = parsed_r;
    cur_nxt        = cur_r;
    fii_nxt        = fii_r;
    acc_nxt        = acc_r;
    held_nxt       = held_r;
    bcnt_nxt       = bcnt_r;
    left_nxt       = left_r;
    au_len_nxt     = au_len_r;
    au_idx_nxt     = au_idx_r;
    fin_kind_nxt   = fin_kind_r;
    consume        = 1'b0;
    store          = 1'b0;
    store_val      = '0;
    emit           = 1'b0;
    ev_kind        = KIND_AU;
    ev_byte        = '0;
    ev_num         = '0;
    ev_len         = '0;
    ev_idx         = '0;
    ev_last        = 1'b0;

    case (state_r)
      ST_LEN_HI: begin
        if (in_full_r) begin
          consume    = 1'b1;
          len_hi_nxt = byte_r;
          if (end_r) begin
            fin_kind_nxt = KIND_ERR;
            state_nxt    = ST_FIN;
          end else begin
            state_nxt = ST_LEN_LO;
          end
        end
      end
      ST_LEN_LO: begin
        if (in_full_r) begin
          consume   = 1'b1;
          lat_s_nxt = cfg_s_r;
          lat_i_nxt = cfg_i_r;
          lat_d_nxt = cfg_d_r;
          if (end_r) begin
            fin_kind_nxt = KIND_ERR;
            state_nxt    = ST_FIN;
          end else if (cfg_s_r == '0 || hdr_total < 16'(si)) begin
            state_nxt = ST_DROP;
          end else begin
            dvd_nxt       = hdr_total - 16'(si);
            rem_nxt       = '0;
            div_cnt_nxt   = 4'd15;
            hdr_bytes_nxt = HB_W'((17'(hdr_total) + 17'd7) >> 3);
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        dvd_nxt     = div_dvd;
        rem_nxt     = div_rem;
        div_cnt_nxt = div_cnt_r - 4'd1;
        if (div_cnt_r == '0) begin
          if (div_dvd >= 16'(MAX_AU_HEADERS)) begin
            state_nxt = ST_DROP;
          end else begin
            hcount_nxt     = CW'(div_dvd) + CW'(1);
            parsed_nxt     = '0;
            fii_nxt        = 1'b0;
            acc_nxt        = '0;
            held_nxt       = '0;
            bytes_seen_nxt = '0;
            bcnt_nxt       = 4'd8;
            state_nxt      = ST_HDR;
          end
        end
      end
      ST_HDR: begin
        if (in_full_r) begin
          if (pending) begin
            store     = 1'b1;
            store_val = acc_r;
          end else if (hdr_more && bcnt_r != '0) begin
            bcnt_nxt = bcnt_r - 4'd1;
            if (shift_held == cur_w) begin
              store     = 1'b1;
              store_val = shift_acc;
            end else begin
              acc_nxt  = shift_acc;
              held_nxt = shift_held;
            end
          end else begin
            consume        = 1'b1;
            bcnt_nxt       = 4'd8;
            bytes_seen_nxt = bytes_seen_r + HB_W'(1);
            if (bytes_seen_r + HB_W'(1) >= hdr_bytes_r) begin
              if (end_r) begin
                fin_kind_nxt = KIND_DONE;
                state_nxt    = ST_FIN;
              end else begin
                cur_nxt   = '0;
                state_nxt = ST_SKIP_RD;
              end
            end else if (end_r) begin
              fin_kind_nxt = KIND_ERR;
              state_nxt    = ST_FIN;
            end
          end
          if (store) begin
            acc_nxt  = '0;
            held_nxt = '0;
            fii_nxt  = !fii_r;
            if (fii_r) begin
              parsed_nxt = parsed_r + CW'(1);
            end
          end
        end
      end
      ST_SKIP_RD: begin
        if (cur_r < hcount_r) begin
          state_nxt = ST_SKIP_CHK;
        end else begin
          left_nxt  = '0;
          state_nxt = ST_PAYLOAD;
        end
      end
      ST_SKIP_CHK: begin
        if (size_rd == '0) begin
          cur_nxt   = cur_r + CW'(1);
          state_nxt = ST_SKIP_RD;
        end else begin
          au_len_nxt = size_rd;
          au_idx_nxt = index_rd;
          left_nxt   = size_rd;
          state_nxt  = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (in_full_r && out_free) begin
          consume = 1'b1;
          if (cur_r < hcount_r) begin
            emit     = 1'b1;
            ev_kind  = KIND_AU;
            ev_byte  = byte_r;
            ev_num   = NUM_W'(cur_r);
            ev_len   = au_len_r;
            ev_idx   = au_idx_r;
            ev_last  = (left_r == 16'd1) || end_r;
            left_nxt = left_r - 16'd1;
            if (left_r == 16'd1) begin
              cur_nxt   = cur_r + CW'(1);
              state_nxt = ST_SKIP_RD;
            end
          end
          if (end_r) begin
            fin_kind_nxt = KIND_DONE;
            state_nxt    = ST_FIN;
          end
        end
      end
      ST_DROP: begin
        if (in_full_r) begin
          consume = 1'b1;
          if (end_r) begin
            fin_kind_nxt = KIND_ERR;
            state_nxt    = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          ev_kind   = fin_kind_r;
          state_nxt = ST_LEN_HI;
        end
      end
      default: begin
        state_nxt = ST_LEN_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LEN_HI;
      in_full_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      cfg_s_r      <= SIZE_BITS_RST;
      cfg_i_r      <= INDEX_BITS_RST;
      cfg_d_r      <= DELTA_BITS_RST;
      bytes_seen_r <= '0;
      div_cnt_r    <= '0;
      hcount_r     <= '0;
      parsed_r     <= '0;
      cur_r        <= '0;
      fii_r        <= 1'b0;
      held_r       <= '0;
      bcnt_r       <= '0;
      left_r       <= '0;
      fin_kind_r   <= KIND_ERR;
    end else begin
      state_r      <= state_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      div_cnt_r    <= div_cnt_nxt;
      hcount_r     <= hcount_nxt;
      parsed_r     <= parsed_nxt;
      cur_r        <= cur_nxt;
      fii_r        <= fii_nxt;
      held_r       <= held_nxt;
      bcnt_r       <= bcnt_nxt;
      left_r       <= left_nxt;
      fin_kind_r   <= fin_kind_nxt;
      if (in_accept) begin
        in_full_r <= 1'b1;
      end else if (consume) begin
        in_full_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SIZE_BITS:  cfg_s_r <= cfg_wdata;
          CFG_INDEX_BITS: cfg_i_r <= cfg_wdata;
          CFG_DELTA_BITS: cfg_d_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r <= in_payload_byte;
      end_r  <= in_packet_end;
    end
    lat_s_r     <= lat_s_nxt;
    lat_i_r     <= lat_i_nxt;
    lat_d_r     <= lat_d_nxt;
    len_hi_r    <= len_hi_nxt;
    hdr_bytes_r <= hdr_bytes_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    acc_r       <= acc_nxt;
    au_len_r    <= au_len_nxt;
    au_idx_r    <= au_idx_nxt;
    if (emit) begin
      ok_kind_r <= ev_kind;
      ob_r      <= ev_byte;
      onum_r    <= ev_num;
      olen_r    <= ev_len;
      oidx_r    <= ev_idx;
      olast_r   <= ev_last;
    end
  end

  auhdp_ram #(
    .WIDTH(LEN_W),
    .DEPTH(MAX_AU_HEADERS)
  ) u_size_ram (
    .clk  (clk),
    .we   (store && !fii_r),
    .waddr(parsed_r[AW-1:0]),
    .wdata(store_val),
    .raddr(cur_r[AW-1:0]),
    .rdata(size_rd)
  );

  auhdp_ram #(
    .WIDTH(LEN_W),
    .DEPTH(MAX_AU_HEADERS)
  ) u_index_ram (
    .clk  (clk),
    .we   (store && fii_r),
    .waddr(parsed_r[AW-1:0]),
    .wdata(store_val),
    .raddr(cur_r[AW-1:0]),
    .rdata(index_rd)
  );

  assign out_valid          = out_valid_r;
  assign out_kind           = ok_kind_r;
  assign out_byte           = ob_r;
  assign out_au_number      = onum_r;
  assign out_au_length      = olen_r;
  assign out_au_index_field = oidx_r;
  assign out_au_last        = olast_r;

endmodule

`default_nettype wire

>>> hdl/auhdp_checker.sv
// ----------------------------------------------------------------------------
// AU header depacketizer port checker
// Watches the result channel of the top level; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "au_header_section_depacketizer_top_macros.svh"

module auhdp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input auhdp_pkg::kind_t             out_kind,
  input logic [auhdp_pkg::BYTE_W-1:0] out_byte,
  input logic [auhdp_pkg::NUM_W-1:0]  out_au_number,
  input logic [auhdp_pkg::LEN_W-1:0]  out_au_length,
  input logic [auhdp_pkg::LEN_W-1:0]  out_au_index_field,
  input logic                         out_au_last
);

  import auhdp_pkg::*;

  `AUHDP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_au_length) && $stable(out_au_last), "stalled result word changed")

  `AUHDP_ASSERT_SAME(a_status_clean, out_valid && out_kind != KIND_AU, out_byte == '0 && out_au_number == '0 && out_au_length == '0 && out_au_index_field == '0 && !out_au_last, "status word carries AU fields")

  `AUHDP_ASSERT_SAME(a_au_len_nonzero, out_valid && out_kind == KIND_AU, out_au_length != '0, "AU byte from a zero-size AU")

  `AUHDP_ASSERT_SAME(a_single_byte_last, out_valid && out_kind == KIND_AU && out_au_length == 16'd1, out_au_last, "one-byte AU without last mark")

endmodule

bind au_header_section_depacketizer_top auhdp_checker u_auhdp_checker (.*);

`default_nettype wire
